@@ sv/ftl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Feature track linker package
// Shared widths, codes and control types for the track linker modules.
// ----------------------------------------------------------------------------
package ftl_pkg;

  localparam int FRAME_W       = 8;
  localparam int FEAT_W        = 12;
  localparam int TRACK_ID_W    = 9;
  localparam int END_W         = 2;
  localparam int MAX_ENTRIES_D = 1024;
  localparam int MAX_TRACKS_D  = 512;

  localparam logic OP_LINK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [END_W-1:0] END_NONE = 2'd0;
  localparam logic [END_W-1:0] END_A    = 2'd1;
  localparam logic [END_W-1:0] END_B    = 2'd2;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic start;
    logic eval;
  } scan_ctrl_t;

  // Status of the scan unit back to the sequencer.
  typedef struct packed {
    logic hit;
    logic best_is_a;
  } scan_stat_t;

endpackage : ftl_pkg
`default_nettype wire

@@ sv/ftl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module ftl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : ftl_ram
`default_nettype wire

@@ sv/ftl_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Track linker scan unit
// Compares one stored entry per cycle against both observations and keeps
// the earliest entry of the lowest-numbered track that holds either one.
// ----------------------------------------------------------------------------
module ftl_scan
  import ftl_pkg::*;
#(
  parameter int TW = 9
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scan_ctrl_t         ctrl,
  input  wire logic [FRAME_W-1:0] a_frame,
  input  wire logic [FEAT_W-1:0]  a_feat,
  input  wire logic [FRAME_W-1:0] b_frame,
  input  wire logic [FEAT_W-1:0]  b_feat,
  input  wire logic [FRAME_W-1:0] rd_frame,
  input  wire logic [FEAT_W-1:0]  rd_feat,
  input  wire logic [TW-1:0]      rd_track,
  output scan_stat_t              stat,
  output logic      [TW-1:0]      best_track
);

  logic hit;
  logic best_is_a;
  logic is_a;
  logic is_b;
  logic take;

  always_comb begin
    is_a = (rd_frame == a_frame) && (rd_feat == a_feat);
    is_b = (rd_frame == b_frame) && (rd_feat == b_feat);
    // Strict compare keeps the earliest entry among equal tracks.
    take = ctrl.eval && (is_a || is_b) && (!hit || (rd_track < best_track));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.start) begin
      hit <= 1'b0;
    end else if (take) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_track <= rd_track;
      best_is_a  <= is_a;
    end
  end

  assign stat.hit       = hit;
  assign stat.best_is_a = best_is_a;

endmodule : ftl_scan
`default_nettype wire

@@ sv/feature_track_linker_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Feature track linker
// Groups pairwise feature matches into tracks held in an entry memory.
// ----------------------------------------------------------------------------
// A link transaction scans every stored entry through the single read port
// of the entry memory, one entry per cycle. When a new track is started, the
// result waits for the extra S_WR_B state, because the two entries are written
// back to back. A clear transaction answers in the cycle after acceptance.
// The block takes one transaction at a time and is ready again the cycle after
// its result is taken. The entry memory needs no clearing after reset.
module feature_track_linker_unit
  import ftl_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_D,
  parameter int MAX_TRACKS  = MAX_TRACKS_D
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire logic [FRAME_W-1:0]    frame_a,
  input  wire logic [FEAT_W-1:0]     feature_a,
  input  wire logic [FRAME_W-1:0]    frame_b,
  input  wire logic [FEAT_W-1:0]     feature_b,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TRACK_ID_W-1:0]      track_id,
  output logic                       new_track,
  output logic [END_W-1:0]           matched_end,
  output logic                       table_full
);

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int EW  = FRAME_W + FEAT_W + TW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WR_B,
    S_OUT
  } state_t;

  state_t state;

  logic [CW-1:0]      entry_count;
  logic [TCW-1:0]     track_count;
  logic [CW-1:0]      scan_idx;
  logic               rd_vld;
  logic [FRAME_W-1:0] a_frame;
  logic [FEAT_W-1:0]  a_feat;
  logic [FRAME_W-1:0] b_frame;
  logic [FEAT_W-1:0]  b_feat;

  logic               rd_en;
  logic               wr_en;
  logic [EW-1:0]      wr_data;
  logic [EW-1:0]      rd_data;
  logic               accept;
  logic               hit_full;
  logic               new_full;
  logic [TW-1:0]      dec_track;
  logic [TW-1:0]      best_track;
  logic [TW+TRACK_ID_W-1:0] track_wide;
  logic               wr_b_side;

  scan_ctrl_t         scan_ctrl;
  scan_stat_t         scan_stat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_en    = (state == S_SCAN) && (scan_idx != entry_count);

  always_comb begin
    hit_full   = (entry_count == CW'(MAX_ENTRIES));
    new_full   = (entry_count >= CW'(MAX_ENTRIES - 1)) ||
                 (track_count == TCW'(MAX_TRACKS));
    dec_track  = scan_stat.hit ? best_track : track_count[TW-1:0];
    track_wide = {{TRACK_ID_W{1'b0}}, dec_track};

    // Append the observation the hit entry does not equal, if there is room;
    // a new track writes the first observation now and the second one in S_WR_B.
    wr_en     = 1'b0;
    wr_b_side = 1'b0;
    if (state == S_DECIDE) begin
      if (scan_stat.hit) begin
        wr_en     = !hit_full;
        wr_b_side = scan_stat.best_is_a;
      end else begin
        wr_en = !new_full;
      end
    end else if (state == S_WR_B) begin
      wr_en     = 1'b1;
      wr_b_side = 1'b1;
    end
    wr_data = wr_b_side ? {b_frame, b_feat, dec_track} : {a_frame, a_feat, dec_track};

    scan_ctrl.start = accept;
    scan_ctrl.eval  = rd_vld;
  end

  ftl_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ENTRIES)
  ) u_entries (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(entry_count[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(scan_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  ftl_scan #(
    .TW(TW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (scan_ctrl),
    .a_frame   (a_frame),
    .a_feat    (a_feat),
    .b_frame   (b_frame),
    .b_feat    (b_feat),
    .rd_frame  (rd_data[EW-1 -: FRAME_W]),
    .rd_feat   (rd_data[TW +: FEAT_W]),
    .rd_track  (rd_data[TW-1:0]),
    .stat      (scan_stat),
    .best_track(best_track)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      entry_count <= '0;
      track_count <= '0;
      scan_idx    <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_frame  <= frame_a;
            a_feat   <= feature_a;
            b_frame  <= frame_b;
            b_feat   <= feature_b;
            scan_idx <= '0;
            if (opcode == OP_CLEAR) begin
              entry_count <= '0;
              track_count <= '0;
              track_id    <= '0;
              new_track   <= 1'b0;
              matched_end <= END_NONE;
              table_full  <= 1'b0;
              out_valid   <= 1'b1;
              state       <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + 1'b1;
          end else if (!rd_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (scan_stat.hit) begin
            track_id    <= track_wide[TRACK_ID_W-1:0];
            new_track   <= 1'b0;
            matched_end <= scan_stat.best_is_a ? END_A : END_B;
            table_full  <= hit_full;
            if (!hit_full) begin
              entry_count <= entry_count + 1'b1;
            end
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else if (new_full) begin
            track_id    <= '0;
            new_track   <= 1'b0;
            matched_end <= END_NONE;
            table_full  <= 1'b1;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else begin
            track_id    <= track_wide[TRACK_ID_W-1:0];
            new_track   <= 1'b1;
            matched_end <= END_NONE;
            table_full  <= 1'b0;
            entry_count <= entry_count + 1'b1;
            state       <= S_WR_B;
          end
        end
        S_WR_B: begin
          entry_count <= entry_count + 1'b1;
          track_count <= track_count + 1'b1;
          out_valid   <= 1'b1;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : feature_track_linker_unit
`default_nettype wire

@@ sv/ftl_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Feature track linker checker
// Port-level checks on the linker's result transactions and busy behavior.
// ----------------------------------------------------------------------------
module ftl_checker
  import ftl_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [TRACK_ID_W-1:0] track_id,
  input wire logic                  new_track,
  input wire logic [END_W-1:0]      matched_end,
  input wire logic                  table_full
);

  // A waiting result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(track_id) &&
      $stable(new_track) && $stable(matched_end) && $stable(table_full))
    else $error("result changed while stalled");

  // The block works on one transaction at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("ready while a result is pending");

  // A new track never comes with a hit or a drop.
  a_new_track: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_track |-> matched_end == END_NONE && !table_full)
    else $error("new track reported with hit or drop");

  // A dropped match without a hit reports track zero.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full && matched_end == END_NONE |-> track_id == '0)
    else $error("dropped match reports a track");

endmodule : ftl_checker

bind feature_track_linker_unit ftl_checker u_ftl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .track_id   (track_id),
  .new_track  (new_track),
  .matched_end(matched_end),
  .table_full (table_full)
);
`default_nettype wire
